// ----- src/mbe_pkg.sv -----
package mbe_pkg;

  localparam int FRAC_BITS = 19;
  localparam int WORD_W    = 32;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int CNT_W     = 10;

  localparam logic [CNT_W-1:0] MAX_ITER_RESET = CNT_W'(100);

  // escape when x^2 + y^2 > 4.0
  localparam logic signed [WORD_W-1:0] ESC_BOUND = WORD_W'(4) << FRAC_BITS;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]         count_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_XY,
    ST_UPD,
    ST_MUL_XX,
    ST_MUL_YY,
    ST_CHK,
    ST_FIN
  } state_t;

  // control from the sequencer to the shared multiplier
  typedef struct packed {
    logic en;
    logic dbl;  // shift one less, which doubles the product
  } mul_ctl_t;

endpackage

// ----- src/mbe_if.sv -----
interface mbe_in_if;
  import mbe_pkg::*;

  logic  valid;
  logic  ready;
  word_t c_real;
  word_t c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

interface mbe_out_if;
  import mbe_pkg::*;

  logic   valid;
  logic   ready;
  count_t escape_count;

  modport source (output valid, output escape_count, input ready);
  modport sink   (input valid, input escape_count, output ready);
endinterface

// ----- src/mbe_mul.sv -----
module mbe_mul (
  input  logic             clk,
  input  mbe_pkg::mul_ctl_t ctl,
  input  mbe_pkg::word_t   a,
  input  mbe_pkg::word_t   b,
  output mbe_pkg::word_t   res
);
  import mbe_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic                     dbl;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod <= a * b;
      dbl  <= ctl.dbl;
    end
  end

  // arithmetic shift then truncate is just a slice of the full product
  assign res = dbl ? prod[FRAC_BITS-1 +: WORD_W] : prod[FRAC_BITS +: WORD_W];

endmodule

// ----- src/mbe_core.sv -----
module mbe_core (
  input  logic              clk,
  input  logic              rst,
  input  mbe_pkg::count_t   max_iterations,
  mbe_in_if.sink            point,
  mbe_out_if.source         result,
  output mbe_pkg::mul_ctl_t mul_ctl,
  output mbe_pkg::word_t    mul_a,
  output mbe_pkg::word_t    mul_b,
  input  mbe_pkg::word_t    mul_res
);
  import mbe_pkg::*;

  state_t state, state_next;

  word_t  cr, ci, x, y, xx, yy;
  word_t  mag;
  logic   esc;
  logic   last_pass;
  logic   out_free;
  count_t pass;
  count_t count;
  logic   out_valid;
  count_t out_count;

  assign mag       = xx + mul_res;
  assign esc       = mag > ESC_BOUND;
  assign last_pass = (pass + CNT_W'(1)) == max_iterations;
  assign out_free  = !out_valid || result.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (point.valid) begin
          state_next = (max_iterations == '0) ? ST_FIN : ST_MUL_XY;
        end
      end
      ST_MUL_XY: state_next = ST_UPD;
      ST_UPD:    state_next = ST_MUL_XX;
      ST_MUL_XX: state_next = ST_MUL_YY;
      ST_MUL_YY: state_next = ST_CHK;
      ST_CHK:    state_next = (esc || last_pass) ? ST_FIN : ST_MUL_XY;
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_ctl     = '0;
    mul_a       = x;
    mul_b       = y;
    point.ready = 1'b0;
    unique case (state)
      ST_IDLE:   point.ready = 1'b1;
      ST_MUL_XY: begin
        mul_ctl.en  = 1'b1;
        mul_ctl.dbl = 1'b1;
      end
      ST_MUL_XX: begin
        mul_ctl.en = 1'b1;
        mul_b      = x;
      end
      ST_MUL_YY: begin
        mul_ctl.en = 1'b1;
        mul_a      = y;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // iteration datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cr    <= point.c_real;
        ci    <= point.c_imag;
        x     <= '0;
        y     <= '0;
        xx    <= '0;
        yy    <= '0;
        pass  <= '0;
        count <= '0;
      end
      ST_UPD: begin
        x <= xx - yy + cr;
        y <= mul_res + ci;
      end
      ST_MUL_YY: xx <= mul_res;
      ST_CHK: begin
        yy <= mul_res;
        if (esc) begin
          count <= pass;
        end else if (last_pass) begin
          count <= max_iterations;
        end else begin
          pass <= pass + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // output register, a result may wait here while the next point is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      out_count <= count;
    end
  end

  assign result.valid        = out_valid;
  assign result.escape_count = out_count;

endmodule

// ----- src/mandelbrot_escape_time_top.sv -----
// Mandelbrot escape-time counter. Each point c (c_real, c_imag, signed 32-bit
// with 19 fraction bits) is iterated z = z^2 + c from zero; escape_count is the
// zero-based pass at which x^2 + y^2 first exceeds 4.0, or max_iterations if it
// never does (0 when max_iterations is 0). One signed 32x32 multiplier is shared
// by the three products of a pass, so a pass steps through ST_MUL_XY, ST_UPD,
// ST_MUL_XX, ST_MUL_YY and ST_CHK; a point runs at most max_iterations passes,
// 100 after reset. point is ready only between points; a finished count waits in
// an output register so the next point can start. Write max_iterations through
// cfg_we/cfg_wdata only while no point is in flight.
module mandelbrot_escape_time_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  mbe_pkg::count_t cfg_wdata,
  mbe_in_if.sink          point,
  mbe_out_if.source       result
);
  import mbe_pkg::*;

  count_t   max_iterations;
  mul_ctl_t mul_ctl;
  word_t    mul_a;
  word_t    mul_b;
  word_t    mul_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= MAX_ITER_RESET;
    end else if (cfg_we) begin
      max_iterations <= cfg_wdata;
    end
  end

  mbe_mul u_mul (
    .clk (clk),
    .ctl (mul_ctl),
    .a   (mul_a),
    .b   (mul_b),
    .res (mul_res)
  );

  mbe_core u_core (
    .clk            (clk),
    .rst            (rst),
    .max_iterations (max_iterations),
    .point          (point),
    .result         (result),
    .mul_ctl        (mul_ctl),
    .mul_a          (mul_a),
    .mul_b          (mul_b),
    .mul_res        (mul_res)
  );

  // a count never exceeds the limit it was run with
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.escape_count <= max_iterations)
    else $error("escape_count above max_iterations");

  // a point transfer starts work, so the next point is not taken right away
  a_busy_after_point: assert property (@(posedge clk) disable iff (rst)
    (point.valid && point.ready) |=> !point.ready)
    else $error("point accepted in back-to-back cycles");

  // the multiplier only runs while a point is in flight
  a_mul_only_busy: assert property (@(posedge clk) disable iff (rst)
    mul_ctl.en |-> !point.ready)
    else $error("multiplier enabled while idle");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid after reset");

endmodule
